@@ rtl/core/asrf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asrf_pkg
// shared types and constants of the audio sample ring fifo
// ----------------------------------------------------------------------------
package asrf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 13;

    // operation codes carried by an input beat
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_PULL  = 2'd1,
        OP_SKIP  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [LEVEL_W-1:0]  level_t;

    // status of one operation on its way to the result register
    typedef struct packed {
        logic   pull_hit;
        logic   starved;
        logic   dropped;
        level_t level;
    } stage_t;

endpackage

@@ rtl/core/asrf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asrf_if
// valid/ready channels of the audio sample ring fifo
// ----------------------------------------------------------------------------
interface asrf_in_if;
    logic               valid;
    logic               ready;
    asrf_pkg::op_t      op;
    asrf_pkg::sample_t  sample_in;
    asrf_pkg::level_t   skip_count;

    modport source (output valid, output op, output sample_in, output skip_count,
                    input ready);
    modport sink   (input valid, input op, input sample_in, input skip_count,
                    output ready);
endinterface

interface asrf_out_if;
    logic               valid;
    logic               ready;
    asrf_pkg::sample_t  sample_out;
    logic               starved;
    logic               dropped;
    asrf_pkg::level_t   level;

    modport source (output valid, output sample_out, output starved, output dropped,
                    output level, input ready);
    modport sink   (input valid, input sample_out, input starved, input dropped,
                    input level, output ready);
endinterface

interface asrf_cfg_if;
    logic               valid;
    logic               ready;
    asrf_pkg::level_t   capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

@@ rtl/core/asrf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asrf_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module asrf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/audio_sample_ring_fifo_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_sample_ring_fifo_top
// ring fifo of signed 16-bit audio samples with a programmable capacity
// ----------------------------------------------------------------------------
// usage
//   din  : one beat per operation (push, pull, skip, clear) with its sample
//          and skip count; taken when valid and ready are both high
//   dout : exactly one result beat per operation: pulled sample, starved
//          and dropped flags, and the fill level after the operation
//   cfg  : capacity write, always ready; only while the block is idle.
//          a write empties the queue; zero counts as one, values above
//          DEPTH saturate to DEPTH
//   throughput: one operation per cycle unless dout is held; set by the
//   single ram port pair (one write for a push, one registered read for
//   a pull)
//   result path: the accepting edge loads the ram read stage, which passes
//   the beat to the result register on dout once that register is free
//   reset: queue empty, capacity DEPTH; the sample store is not cleared
//   (only written slots are ever read), so there is no clearing pass
//   stall: a held dout keeps its beat; one more operation waits in the
//   ram read stage and then din ready drops until dout is taken
// ----------------------------------------------------------------------------
module audio_sample_ring_fifo_top #(
    parameter int DEPTH = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    asrf_in_if.sink      din,
    asrf_out_if.source   dout,
    asrf_cfg_if.sink     cfg
);

    localparam int AW      = $clog2(DEPTH);
    // capacity register is 13 bits wide, so it can never exceed this
    localparam int CAP_MAX = (DEPTH > 8191) ? 8191 : DEPTH;
    // pointer sums need one bit above the level width
    localparam int PW      = asrf_pkg::LEVEL_W + 1;

    // configuration and queue state
    asrf_pkg::level_t  cap_reg;
    asrf_pkg::level_t  level_reg,  level_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;
    logic [AW-1:0]     wr_idx_reg, wr_idx_next;

    // ram read stage and result register
    logic              s1_valid_reg;
    asrf_pkg::stage_t  s1_reg, s1_next;
    logic              out_valid_reg;
    asrf_pkg::sample_t out_sample_reg;
    asrf_pkg::stage_t  out_stat_reg;

    logic              accept;
    logic              s1_move;
    logic              ram_we;
    logic              ram_re;
    asrf_pkg::sample_t ram_rdata;
    asrf_pkg::level_t  cfg_cap;

    // pointer arithmetic
    logic [PW-1:0]     rd_w, wr_w, cap_w;
    logic [PW-1:0]     rd_inc, wr_inc, rd_skip_sum;
    logic [PW-1:0]     rd_inc_wrap, wr_inc_wrap, rd_skip_wrap;
    asrf_pkg::level_t  skip_n;
    logic              full;

    // ------------------------------------------------------------------
    // handshakes: the result register frees the read stage, which frees din
    // ------------------------------------------------------------------
    assign s1_move   = s1_valid_reg && (!out_valid_reg || dout.ready);
    assign din.ready = !s1_valid_reg || s1_move;
    assign accept    = din.valid && din.ready;
    assign cfg.ready = 1'b1;

    // effective capacity, worked out once when the register is written
    always_comb
    begin
        if (cfg.capacity == '0)
        begin
            cfg_cap = asrf_pkg::level_t'(1);
        end
        else if (int'(cfg.capacity) > DEPTH)
        begin
            cfg_cap = asrf_pkg::level_t'(CAP_MAX);
        end
        else
        begin
            cfg_cap = cfg.capacity;
        end
    end

    // ------------------------------------------------------------------
    // index wrap: every index stays below the capacity, so a single
    // compare and subtract is enough, also for a skip (count <= level)
    // ------------------------------------------------------------------
    assign rd_w  = PW'(rd_idx_reg);
    assign wr_w  = PW'(wr_idx_reg);
    assign cap_w = PW'(cap_reg);

    assign rd_inc      = rd_w + PW'(1);
    assign wr_inc      = wr_w + PW'(1);
    assign rd_inc_wrap = (rd_inc >= cap_w) ? '0 : rd_inc;
    assign wr_inc_wrap = (wr_inc >= cap_w) ? '0 : wr_inc;

    // skip count clamped to what is held
    assign skip_n       = (din.skip_count > level_reg) ? level_reg : din.skip_count;
    assign rd_skip_sum  = rd_w + PW'(skip_n);
    assign rd_skip_wrap = (rd_skip_sum >= cap_w) ? (rd_skip_sum - cap_w) : rd_skip_sum;

    assign full = (level_reg >= cap_reg);

    // ------------------------------------------------------------------
    // operation decode
    // ------------------------------------------------------------------
    always_comb
    begin
        level_next  = level_reg;
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        s1_next     = '0;

        unique case (din.op)
            asrf_pkg::OP_PUSH:
            begin
                ram_we      = accept;
                wr_idx_next = AW'(wr_inc_wrap);
                if (full)
                begin
                    // oldest sample goes, level stays at capacity
                    s1_next.dropped = 1'b1;
                    rd_idx_next     = AW'(rd_inc_wrap);
                end
                else
                begin
                    level_next = level_reg + asrf_pkg::level_t'(1);
                end
            end
            asrf_pkg::OP_PULL:
            begin
                if (level_reg == '0)
                begin
                    s1_next.starved = 1'b1;
                end
                else
                begin
                    s1_next.pull_hit = 1'b1;
                    ram_re           = accept;
                    rd_idx_next      = AW'(rd_inc_wrap);
                    level_next       = level_reg - asrf_pkg::level_t'(1);
                end
            end
            asrf_pkg::OP_SKIP:
            begin
                rd_idx_next = AW'(rd_skip_wrap);
                level_next  = level_reg - skip_n;
            end
            asrf_pkg::OP_CLEAR:
            begin
                rd_idx_next = '0;
                wr_idx_next = '0;
                level_next  = '0;
            end
            default:
            begin
                level_next = level_reg;
            end
        endcase

        s1_next.level = level_next;
    end

    // ------------------------------------------------------------------
    // queue state; a capacity write empties the queue
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= asrf_pkg::level_t'(CAP_MAX);
            level_reg  <= '0;
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
        end
        else if (cfg.valid)
        begin
            cap_reg    <= cfg_cap;
            level_reg  <= '0;
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
        end
        else if (accept)
        begin
            level_reg  <= level_next;
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
        end
    end

    // ------------------------------------------------------------------
    // sample store; read data holds until the next pull is accepted
    // ------------------------------------------------------------------
    asrf_ram #(
        .WIDTH (asrf_pkg::SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (din.sample_in),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // read stage and result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_move)
        begin
            out_stat_reg   <= s1_reg;
            out_sample_reg <= s1_reg.pull_hit ? ram_rdata : '0;
        end
    end

    assign dout.valid      = out_valid_reg;
    assign dout.sample_out = out_sample_reg;
    assign dout.starved    = out_stat_reg.starved;
    assign dout.dropped    = out_stat_reg.dropped;
    assign dout.level      = out_stat_reg.level;

endmodule

@@ rtl/core/asrf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asrf_checker
// port level checks of the audio sample ring fifo
// ----------------------------------------------------------------------------
module asrf_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input asrf_pkg::sample_t sample_out,
    input logic              starved,
    input logic              dropped,
    input asrf_pkg::level_t  level
);

    // held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out)
            && $stable(level) && $stable(starved) && $stable(dropped))
        else $error("result beat changed while stalled");

    // a starved pull leaves an empty queue and a zero sample
    a_starved: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && starved |-> sample_out == '0 && level == '0 && !dropped)
        else $error("starved result with data or level");

    // a push that drops the oldest sample leaves a full, non-empty queue
    a_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped |-> level != '0 && !starved && sample_out == '0)
        else $error("dropped result inconsistent");

    // no result beat straight out of reset
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result beat during reset");

endmodule

bind audio_sample_ring_fifo_top asrf_checker u_asrf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .sample_out (dout.sample_out),
    .starved    (dout.starved),
    .dropped    (dout.dropped),
    .level      (dout.level)
);

@@ bench/audio_sample_ring_fifo_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_sample_ring_fifo_top_tb
// self-checking bench for the audio sample ring fifo
// ----------------------------------------------------------------------------
// A queue-fed driver sends operation beats. As each beat is taken, a
// bit-accurate ring model predicts the result, and a monitor checks every
// result beat against it. The run goes through a series of capacity
// settings, including zero and oversized values. Each setting gets a burst of
// fill/drain-biased random traffic. Both handshakes stall at random, and the
// receiver twice holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module audio_sample_ring_fifo_top_tb;

    localparam int RING_DEPTH  = 4096;
    localparam int QUIET_LIMIT = 3000;   // cycles without any beat before giving up
    localparam int HOLD_CYCLES = 200;    // long receiver hold-off
    localparam int N_PHASES    = 10;

    typedef struct packed {
        asrf_pkg::op_t     op;
        asrf_pkg::sample_t smp;
        asrf_pkg::level_t  count;
    } ring_op_t;

    typedef struct packed {
        asrf_pkg::sample_t smp;
        logic              starved;
        logic              dropped;
        asrf_pkg::level_t  level;
    } ring_result_t;

    logic clk;
    logic rst_n;

    asrf_in_if  din_if ();
    asrf_out_if dout_if ();
    asrf_cfg_if cfg_if ();

    audio_sample_ring_fifo_top #(
        .DEPTH (RING_DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if),
        .cfg   (cfg_if)
    );

    // ring model state, mirrors the block after reset
    asrf_pkg::sample_t ring_store [RING_DEPTH];
    int unsigned       ring_rd   = 0;
    int unsigned       ring_wr   = 0;
    int unsigned       ring_fill = 0;
    asrf_pkg::level_t  ring_cap  = asrf_pkg::level_t'(RING_DEPTH);

    ring_op_t     pending_ops [$];
    ring_result_t results_due [$];

    // capacity per phase; phase 0 runs on the reset value
    asrf_pkg::level_t phase_cap [N_PHASES] = '{13'd0, 13'd3, 13'd1, 13'd0, 13'd8191,
                                               13'd2, 13'd4097, 13'd4096, 13'd29, 13'd5};
    int unsigned phase_len [N_PHASES] = '{150, 150, 150, 120, 40,
                                          150, 100, 120, 200, 150};
    int unsigned hold_marks [2] = '{400, 1000};

    int unsigned ops_accepted = 0;
    int unsigned n_errors     = 0;
    int unsigned n_pulled     = 0;
    int unsigned n_starved    = 0;
    int unsigned n_dropped    = 0;
    int unsigned n_skips      = 0;
    int unsigned n_clears     = 0;
    int unsigned n_cap_writes = 0;

    int unsigned send_gap     = 0;
    bit          send_burst   = 1'b0;
    int unsigned recv_stall   = 0;
    bit          recv_burst   = 1'b0;
    bit          hold_off     = 1'b0;
    int unsigned quiet_cycles = 0;

    // capacity in force: zero acts as one, oversize clips to the store depth
    function automatic int unsigned ring_size();
        if (ring_cap == 0)
            return 1;
        if (ring_cap > RING_DEPTH)
            return RING_DEPTH;
        return ring_cap;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned random_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // apply one operation to the ring model and return the expected result beat
    function automatic ring_result_t ring_apply(ring_op_t item);
        ring_result_t res;
        int unsigned  cap;
        int unsigned  n;
        res = '0;
        cap = ring_size();
        case (item.op)
            asrf_pkg::OP_PUSH:
            begin
                // full: oldest sample goes first
                if (ring_fill >= cap)
                begin
                    res.dropped = 1'b1;
                    ring_rd     = (ring_rd + 1) % cap;
                    ring_fill   = cap - 1;
                    n_dropped++;
                end
                ring_store[ring_wr] = item.smp;
                ring_wr             = (ring_wr + 1) % cap;
                ring_fill++;
            end
            asrf_pkg::OP_PULL:
            begin
                if (ring_fill == 0)
                begin
                    res.starved = 1'b1;
                    n_starved++;
                end
                else
                begin
                    res.smp   = ring_store[ring_rd];
                    ring_rd   = (ring_rd + 1) % cap;
                    ring_fill--;
                    n_pulled++;
                end
            end
            asrf_pkg::OP_SKIP:
            begin
                n         = (item.count > ring_fill) ? ring_fill : item.count;
                ring_rd   = (ring_rd + n) % cap;
                ring_fill = ring_fill - n;
                n_skips++;
            end
            default:
            begin
                ring_rd   = 0;
                ring_wr   = 0;
                ring_fill = 0;
                n_clears++;
            end
        endcase
        res.level = asrf_pkg::level_t'(ring_fill);
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s at %0t ns: got %0d, expected %0d", what, $time, got, want);
        n_errors++;
    endtask

    function automatic void add_op(asrf_pkg::op_t op, asrf_pkg::sample_t smp,
                                   asrf_pkg::level_t count);
        ring_op_t item;
        item.op    = op;
        item.smp   = smp;
        item.count = count;
        pending_ops.push_back(item);
    endfunction

    // random traffic in alternating fill and drain stretches
    task automatic queue_random_ops(int unsigned count, int unsigned cap_hint);
        int unsigned       r;
        int unsigned       seg;
        bit                filling;
        asrf_pkg::op_t     op;
        asrf_pkg::sample_t smp;
        asrf_pkg::level_t  cnt;
        filling = 1'b1;
        seg     = $urandom_range(16, 48);
        repeat (count)
        begin
            if (seg == 0)
            begin
                filling = !filling;
                seg     = $urandom_range(16, 48);
            end
            seg--;
            r = $urandom_range(0, 99);
            if (r < (filling ? 65 : 25))
                op = asrf_pkg::OP_PUSH;
            else if (r < (filling ? 85 : 80))
                op = asrf_pkg::OP_PULL;
            else if (r < 96)
                op = asrf_pkg::OP_SKIP;
            else
                op = asrf_pkg::OP_CLEAR;
            r = $urandom_range(0, 99);
            if (r < 4)
                smp = 16'sh8000;
            else if (r < 8)
                smp = 16'sh7FFF;
            else
                smp = asrf_pkg::sample_t'($urandom);
            r = $urandom_range(0, 99);
            if (r < 60)
                cnt = asrf_pkg::level_t'($urandom_range(0, 4));
            else if (r < 90)
                cnt = asrf_pkg::level_t'($urandom_range(0, cap_hint));
            else
                cnt = asrf_pkg::level_t'($urandom_range(0, 8191));
            add_op(op, smp, cnt);
        end
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || din_if.valid || results_due.size() != 0)
            @(posedge clk);
    endtask

    // clock and the single reset pulse
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // operation driver: predicts each beat as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        ring_op_t nxt;
        if (!rst_n)
        begin
            din_if.valid      <= 1'b0;
            din_if.op         <= asrf_pkg::OP_PUSH;
            din_if.sample_in  <= '0;
            din_if.skip_count <= '0;
        end
        else
        begin
            if (din_if.valid && din_if.ready)
            begin
                nxt.op    = din_if.op;
                nxt.smp   = din_if.sample_in;
                nxt.count = din_if.skip_count;
                results_due.push_back(ring_apply(nxt));
                ops_accepted++;
            end
            if (!din_if.valid || din_if.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    din_if.valid <= 1'b0;
                end
                else if (pending_ops.size() != 0)
                begin
                    nxt = pending_ops.pop_front();
                    din_if.valid      <= 1'b1;
                    din_if.op         <= nxt.op;
                    din_if.sample_in  <= nxt.smp;
                    din_if.skip_count <= nxt.count;
                    // occasional back-to-back stretches with no idling
                    if ($urandom_range(0, 79) == 0)
                        send_burst = !send_burst;
                    send_gap = send_burst ? 0 : random_gap();
                end
                else
                    din_if.valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        ring_result_t want;
        if (!rst_n)
            dout_if.ready <= 1'b0;
        else
        begin
            if (dout_if.valid && dout_if.ready)
            begin
                if (results_due.size() == 0)
                    report_mismatch("result beat with nothing outstanding, level",
                                    dout_if.level, -1);
                else
                begin
                    want = results_due.pop_front();
                    if (dout_if.sample_out !== want.smp)
                        report_mismatch("sample_out", dout_if.sample_out, want.smp);
                    if (dout_if.starved !== want.starved)
                        report_mismatch("starved", dout_if.starved, want.starved);
                    if (dout_if.dropped !== want.dropped)
                        report_mismatch("dropped", dout_if.dropped, want.dropped);
                    if (dout_if.level !== want.level)
                        report_mismatch("level", dout_if.level, want.level);
                end
            end
            if (hold_off)
                dout_if.ready <= 1'b0;
            else if (recv_stall != 0)
            begin
                recv_stall--;
                dout_if.ready <= 1'b0;
            end
            else
            begin
                dout_if.ready <= 1'b1;
                if ($urandom_range(0, 99) == 0)
                    recv_burst = !recv_burst;
                if (!recv_burst && $urandom_range(0, 3) == 0)
                    recv_stall = random_gap();
            end
        end
    end

    // long receiver hold-offs so the block fills and stalls its input
    initial
    begin
        foreach (hold_marks[i])
        begin
            while (ops_accepted < hold_marks[i])
                @(posedge clk);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("no beat taken on any channel for %0d cycles", QUIET_LIMIT);
                    $display("** audio_sample_ring_fifo_top: FAILED **");
                    $finish;
                end
            end
        end
    end

    // stimulus: capacity phases, each written only once the ring has drained
    initial
    begin
        cfg_if.valid    <= 1'b0;
        cfg_if.capacity <= '0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p != 0)
            begin
                wait_drained();
                @(posedge clk);
                cfg_if.valid    <= 1'b1;
                cfg_if.capacity <= phase_cap[p];
                do
                    @(posedge clk);
                while (!cfg_if.ready);
                cfg_if.valid <= 1'b0;
                // a capacity write empties the ring
                ring_cap  = phase_cap[p];
                ring_rd   = 0;
                ring_wr   = 0;
                ring_fill = 0;
                n_cap_writes++;
            end
            if (p == 0)
            begin
                // empty pull and skips, extremes, clamped skip, clear
                add_op(asrf_pkg::OP_PULL, '0, '0);
                add_op(asrf_pkg::OP_SKIP, '0, '0);
                add_op(asrf_pkg::OP_SKIP, '0, 13'd8191);
                add_op(asrf_pkg::OP_PUSH, 16'sh8000, '0);
                add_op(asrf_pkg::OP_PUSH, 16'sh7FFF, '0);
                add_op(asrf_pkg::OP_PUSH, '0, '0);
                add_op(asrf_pkg::OP_PUSH, 16'shFFFF, '0);
                add_op(asrf_pkg::OP_PUSH, 16'sh5A5A, '0);
                add_op(asrf_pkg::OP_PULL, '0, '0);
                add_op(asrf_pkg::OP_SKIP, '0, 13'd2);
                add_op(asrf_pkg::OP_PULL, '0, '0);
                add_op(asrf_pkg::OP_PULL, '0, '0);
                add_op(asrf_pkg::OP_PULL, '0, '0);
                add_op(asrf_pkg::OP_PUSH, 16'sd123, '0);
                add_op(asrf_pkg::OP_CLEAR, '0, '0);
                add_op(asrf_pkg::OP_PULL, '0, '0);
            end
            else if (p == 1)
            begin
                // capacity three: overwrite on full, skip past the level
                add_op(asrf_pkg::OP_PUSH, 16'sd1, '0);
                add_op(asrf_pkg::OP_PUSH, 16'sd2, '0);
                add_op(asrf_pkg::OP_PUSH, 16'sd3, '0);
                add_op(asrf_pkg::OP_PUSH, 16'sd4, '0);
                add_op(asrf_pkg::OP_PULL, '0, '0);
                add_op(asrf_pkg::OP_SKIP, '0, 13'd4096);
                add_op(asrf_pkg::OP_PULL, '0, '0);
                add_op(asrf_pkg::OP_PUSH, -16'sd7, '0);
                add_op(asrf_pkg::OP_CLEAR, '0, '0);
            end
            queue_random_ops(phase_len[p], ring_size());
        end
        wait_drained();
        repeat (8) @(posedge clk);
        $display("ran %0d operations over %0d capacity writes (zero, one to 29, 4096, oversize)",
                 ops_accepted, n_cap_writes);
        $display("pulled %0d, starved %0d, dropped %0d, skips %0d, clears %0d",
                 n_pulled, n_starved, n_dropped, n_skips, n_clears);
        if (n_errors == 0)
            $display("** audio_sample_ring_fifo_top: PASSED **");
        else
            $display("** audio_sample_ring_fifo_top: FAILED **");
        $finish;
    end

endmodule
